// ===== hw/rtl/wtpf_pkg.sv =====
// wtpf_pkg: shared constants for the windowed top-four peak finder
// no dependencies; imported by every module of the block

package wtpf_pkg;

	localparam int BIN_W          = 12;
	localparam int WIN_LEN_W      = 5;
	localparam int WIN_LEFT_W     = 4;
	localparam int CFG_DATA_W     = 12;
	localparam int CFG_INDEX_W    = 1;
	localparam int NUM_SLOTS_DEF  = 4;
	localparam int COUNT_W_DEF    = 24;

	localparam logic [BIN_W-1:0]     START_BIN_RESET  = 12'd280;
	localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RESET = 5'd6;
	localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_MAX   = 5'd16;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_START_BIN  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = 1'd1;

endpackage

// ===== hw/rtl/windowed_top4_peak_finder_core.sv =====
// windowed_top4_peak_finder_core: top level, input register and configuration
// depends on wtpf_pkg, wtpf_slot_tracker and wtpf_result_buf
//
// channel  | dir | tdata (low bit up)                         | tlast
// s_*      | in  | bin_index, bin_count, zero pad             | final_bin
// m_*      | out | slot_number, peak_bin, peak_count, zero pad | last_result
// cfg_*    | in  | write enable, register index, write data   | -
//
// one bin per cycle: an item is registered, the slot update runs in the next cycle
// the final bin hands its slot set to the result buffer, which sends NUM_SLOTS
// results at one per cycle while m_tready is high; bins keep flowing meanwhile
// a final bin waits in the input register only while the previous set is still
// being sent, so two final bins must be at least NUM_SLOTS bins apart to avoid a stall
// reset clears all slots, closes any window and loads the default registers

module windowed_top4_peak_finder_core #(
	parameter int NUM_SLOTS = wtpf_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_W   = wtpf_pkg::COUNT_W_DEF,
	parameter int SLOT_W    = $clog2(NUM_SLOTS),
	parameter int IN_W      = ((wtpf_pkg::BIN_W + COUNT_W + 7) / 8) * 8,
	parameter int OUT_W     = ((SLOT_W + wtpf_pkg::BIN_W + COUNT_W + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_W-1:0]                  s_tdata,   // bin_index, bin_count
	input  logic                             s_tlast,   // final_bin
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata,   // slot_number, peak_bin, peak_count
	output logic                             m_tlast,   // last_result
	input  logic                             cfg_we,
	input  logic [wtpf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wtpf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import wtpf_pkg::*;

	logic [BIN_W-1:0]     start_bin_q;
	logic [WIN_LEN_W-1:0] window_len_q;

	logic               valid_s1;
	logic [BIN_W-1:0]   bin_index_s1;
	logic [COUNT_W-1:0] bin_count_s1;
	logic               final_bin_s1;
	logic               advance;
	logic               snap_free;

	logic [COUNT_W-1:0] snap_counts [NUM_SLOTS];
	logic [BIN_W-1:0]   snap_bins [NUM_SLOTS];
	logic [SLOT_W-1:0]  res_slot;
	logic [BIN_W-1:0]   res_bin;
	logic [COUNT_W-1:0] res_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bin_q  <= START_BIN_RESET;
			window_len_q <= WINDOW_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_BIN:  start_bin_q  <= cfg_wdata[BIN_W-1:0];
				REG_WINDOW_LEN: window_len_q <= cfg_wdata[WIN_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// a final bin may only step once the result buffer can take its slot set
	assign advance  = valid_s1 && (!final_bin_s1 || snap_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			bin_index_s1 <= s_tdata[BIN_W-1:0];
			bin_count_s1 <= s_tdata[BIN_W+COUNT_W-1:BIN_W];
			final_bin_s1 <= s_tlast;
		end
	end

	wtpf_slot_tracker #(
		.NUM_SLOTS (NUM_SLOTS),
		.COUNT_W   (COUNT_W),
		.SLOT_W    (SLOT_W)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.bin_index   (bin_index_s1),
		.bin_count   (bin_count_s1),
		.final_bin   (final_bin_s1),
		.start_bin   (start_bin_q),
		.window_len  (window_len_q),
		.snap_counts (snap_counts),
		.snap_bins   (snap_bins)
	);

	wtpf_result_buf #(
		.NUM_SLOTS (NUM_SLOTS),
		.COUNT_W   (COUNT_W),
		.SLOT_W    (SLOT_W)
	) u_result_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && final_bin_s1),
		.load_counts (snap_counts),
		.load_bins   (snap_bins),
		.free        (snap_free),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_slot    (res_slot),
		.res_bin     (res_bin),
		.res_count   (res_count),
		.res_last    (m_tlast)
	);

	assign m_tdata = OUT_W'({res_count, res_bin, res_slot});

`ifndef ASSERT_OFF
	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(final_bin_s1) && final_bin_s1))
		else $error("held input item changed or was dropped");
`endif

endmodule

// ===== hw/rtl/wtpf_slot_tracker.sv =====
// wtpf_slot_tracker: peak slot registers, window state and per-bin update
// depends on wtpf_pkg; feeds the finished slot set to wtpf_result_buf

module wtpf_slot_tracker #(
	parameter int NUM_SLOTS = wtpf_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_W   = wtpf_pkg::COUNT_W_DEF,
	parameter int SLOT_W    = $clog2(NUM_SLOTS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [wtpf_pkg::BIN_W-1:0]    bin_index,
	input  logic [COUNT_W-1:0]            bin_count,
	input  logic                          final_bin,
	input  logic [wtpf_pkg::BIN_W-1:0]    start_bin,
	input  logic [wtpf_pkg::WIN_LEN_W-1:0] window_len,
	output logic [COUNT_W-1:0]            snap_counts [NUM_SLOTS],
	output logic [wtpf_pkg::BIN_W-1:0]    snap_bins [NUM_SLOTS]
);
	import wtpf_pkg::*;

	logic [COUNT_W-1:0]    counts_q [NUM_SLOTS];
	logic [BIN_W-1:0]      bins_q [NUM_SLOTS];
	logic [WIN_LEFT_W-1:0] win_left_q;
	logic [SLOT_W-1:0]     win_slot_q;

	logic [COUNT_W-1:0]    counts_d [NUM_SLOTS];
	logic [BIN_W-1:0]      bins_d [NUM_SLOTS];
	logic [WIN_LEFT_W-1:0] win_left_d;
	logic [SLOT_W-1:0]     win_slot_d;
	logic [COUNT_W-1:0]    min_cnt;
	logic [SLOT_W-1:0]     pick;
	logic [WIN_LEFT_W-1:0] len_m1;

	// window length clamped to 1..16, less the opening bin
	always_comb begin
		if (window_len == '0) begin
			len_m1 = '0;
		end else if (window_len > WINDOW_LEN_MAX) begin
			len_m1 = WIN_LEFT_W'(WINDOW_LEN_MAX - 5'd1);
		end else begin
			len_m1 = WIN_LEFT_W'(window_len - 5'd1);
		end
	end

	// first slot holding the smallest count
	always_comb begin
		min_cnt = counts_q[0];
		pick    = '0;
		for (int s = 1; s < NUM_SLOTS; s++) begin
			if (counts_q[s] < min_cnt) begin
				min_cnt = counts_q[s];
				pick    = SLOT_W'(s);
			end
		end
	end

	always_comb begin
		counts_d   = counts_q;
		bins_d     = bins_q;
		win_left_d = win_left_q;
		win_slot_d = win_slot_q;
		if (win_left_q != '0) begin
			if (bin_count > counts_q[win_slot_q]) begin
				counts_d[win_slot_q] = bin_count;
				bins_d[win_slot_q]   = bin_index;
			end
			win_left_d = win_left_q - WIN_LEFT_W'(1);
		end else if (bin_index >= start_bin) begin
			if (bin_count > min_cnt) begin
				counts_d[pick] = bin_count;
				bins_d[pick]   = bin_index;
				win_slot_d     = pick;
				win_left_d     = len_m1;
			end
		end
	end

	assign snap_counts = counts_d;
	assign snap_bins   = bins_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				counts_q[s] <= '0;
				bins_q[s]   <= '0;
			end
			win_left_q <= '0;
			win_slot_q <= '0;
		end else if (step_en) begin
			if (final_bin) begin
				// slots go out through the result buffer, start afresh
				for (int s = 0; s < NUM_SLOTS; s++) begin
					counts_q[s] <= '0;
					bins_q[s]   <= '0;
				end
				win_left_q <= '0;
				win_slot_q <= '0;
			end else begin
				counts_q   <= counts_d;
				bins_q     <= bins_d;
				win_left_q <= win_left_d;
				win_slot_q <= win_slot_d;
			end
		end
	end

`ifndef ASSERT_OFF
	a_final_closes_window: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && final_bin) |=> (win_left_q == '0 && counts_q[0] == '0))
		else $error("window or slot survived the final bin");
	a_window_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && !final_bin && win_left_q != '0) |=>
			(win_left_q == $past(win_left_q) - WIN_LEFT_W'(1)))
		else $error("open window did not count down");
`endif

endmodule

// ===== hw/rtl/wtpf_result_buf.sv =====
// wtpf_result_buf: holds one finished slot set and sends it a slot per transfer
// depends on wtpf_pkg; loaded from wtpf_slot_tracker

module wtpf_result_buf #(
	parameter int NUM_SLOTS = wtpf_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_W   = wtpf_pkg::COUNT_W_DEF,
	parameter int SLOT_W    = $clog2(NUM_SLOTS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [COUNT_W-1:0]         load_counts [NUM_SLOTS],
	input  logic [wtpf_pkg::BIN_W-1:0] load_bins [NUM_SLOTS],
	output logic                       free,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [SLOT_W-1:0]          res_slot,
	output logic [wtpf_pkg::BIN_W-1:0] res_bin,
	output logic [COUNT_W-1:0]         res_count,
	output logic                       res_last
);
	import wtpf_pkg::*;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	logic [COUNT_W-1:0] counts_q [NUM_SLOTS];
	logic [BIN_W-1:0]   bins_q [NUM_SLOTS];
	logic               valid_q;
	logic [SLOT_W-1:0]  ptr_q;
	logic               xfer;

	assign xfer      = valid_q && res_ready;
	assign free      = !valid_q || (xfer && ptr_q == LAST_SLOT);
	assign res_valid = valid_q;
	assign res_slot  = ptr_q;
	assign res_bin   = bins_q[ptr_q];
	assign res_count = counts_q[ptr_q];
	assign res_last  = (ptr_q == LAST_SLOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			ptr_q   <= '0;
		end else if (xfer) begin
			if (ptr_q == LAST_SLOT) begin
				valid_q <= 1'b0;
				ptr_q   <= '0;
			end else begin
				ptr_q <= ptr_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			counts_q <= load_counts;
			bins_q   <= load_bins;
		end
	end

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("slot set loaded over one still being sent");
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && ptr_q == LAST_SLOT && !load) |=> !valid_q)
		else $error("buffer still valid after its last slot transfer");
`endif

endmodule

// ===== tb/windowed_top4_peak_finder_core_test.sv =====
// windowed_top4_peak_finder_core_test: self-checking bench for the peak finder core
// depends on wtpf_pkg and windowed_top4_peak_finder_core; streams histograms with
// random stalls, predicts the slot reports and checks every result transfer

module windowed_top4_peak_finder_core_test;
	import wtpf_pkg::*;

	localparam int NSLOT          = NUM_SLOTS_DEF;
	localparam int CNT_W          = COUNT_W_DEF;
	localparam int SLOT_W         = $clog2(NSLOT);
	localparam int IN_W           = ((BIN_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_W          = ((SLOT_W + BIN_W + CNT_W + 7) / 8) * 8;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [BIN_W-1:0]  bin;
		logic [CNT_W-1:0]  count;
		logic              last;
	} peak_rpt_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata = '0;   // bin_index, bin_count, zero pad
	logic                   s_tlast = 1'b0; // final_bin
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_W-1:0]       m_tdata;        // slot_number, peak_bin, peak_count, zero pad
	logic                   m_tlast;        // last_result
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	windowed_top4_peak_finder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted peak slots and register copies
	logic [CNT_W-1:0]     slot_cnt [NSLOT];
	logic [BIN_W-1:0]     slot_bin [NSLOT];
	logic [3:0]           win_left;
	logic [SLOT_W-1:0]    win_slot;
	logic [BIN_W-1:0]     cfg_start;
	logic [WIN_LEN_W-1:0] cfg_len;

	peak_rpt_t peak_expect_q[$];

	int  fail_count = 0;
	int  bins_sent = 0;
	int  hists_sent = 0;
	int  results_checked = 0;
	int  quiet_cycles = 0;
	bit  tx_idle = 1'b0;
	bit  rx_idle = 1'b0;
	bit  hold_req = 1'b0;

	function automatic void clear_peaks();
		for (int s = 0; s < NSLOT; s++) begin
			slot_cnt[s] = '0;
			slot_bin[s] = '0;
		end
		win_left = '0;
		win_slot = '0;
	endfunction

	function automatic void track_bin(logic [BIN_W-1:0] idx, logic [CNT_W-1:0] cnt, logic fin);
		logic [CNT_W-1:0]     lowest;
		int                   pick;
		logic [WIN_LEN_W-1:0] span;
		peak_rpt_t            rpt;
		if (win_left != 0) begin
			if (cnt > slot_cnt[win_slot]) begin
				slot_cnt[win_slot] = cnt;
				slot_bin[win_slot] = idx;
			end
			win_left = win_left - 1'b1;
		end else if (idx >= cfg_start) begin
			// first slot holding the minimum wins a tie
			lowest = slot_cnt[0];
			pick = 0;
			for (int s = 1; s < NSLOT; s++) begin
				if (slot_cnt[s] < lowest) begin
					lowest = slot_cnt[s];
					pick = s;
				end
			end
			if (cnt > lowest) begin
				slot_cnt[pick] = cnt;
				slot_bin[pick] = idx;
				win_slot = pick[SLOT_W-1:0];
				if (cfg_len == 0)
					span = 1;
				else if (cfg_len > WINDOW_LEN_MAX)
					span = WINDOW_LEN_MAX;
				else
					span = cfg_len;
				win_left = 4'(span - 1'b1);
			end
		end
		if (fin) begin
			for (int s = 0; s < NSLOT; s++) begin
				rpt.slot  = s[SLOT_W-1:0];
				rpt.bin   = slot_bin[s];
				rpt.count = slot_cnt[s];
				rpt.last  = (s == NSLOT - 1);
				peak_expect_q.push_back(rpt);
			end
			clear_peaks();
		end
	endfunction

	// valid is left high after a transfer; the next call or drain decides its level
	task automatic send_bin(input logic [BIN_W-1:0] idx, input logic [CNT_W-1:0] cnt,
			input logic fin);
		int gap;
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - BIN_W - CNT_W){1'b0}}, cnt, idx};
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track_bin(idx, cnt, fin);
		bins_sent++;
		if (fin)
			hists_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (peak_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers in consecutive cycles, enable held high between them
	task automatic write_config(input logic [CFG_DATA_W-1:0] start_val,
			input logic [CFG_DATA_W-1:0] len_val);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_BIN;
		cfg_wdata <= start_val;
		cfg_start = start_val[BIN_W-1:0];
		@(posedge clk);
		cfg_index <= REG_WINDOW_LEN;
		cfg_wdata <= len_val;
		cfg_len = len_val[WIN_LEN_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_histogram(input int len, input bit scramble, input bit closed);
		logic [BIN_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
		idx = BIN_W'($urandom_range(0, (1 << BIN_W) - 1 - 3 * len));
		for (int k = 0; k < len; k++) begin
			if (scramble)
				idx = BIN_W'($urandom_range(0, (1 << BIN_W) - 1));
			case ($urandom_range(0, 7))
				0:       cnt = CNT_W'($urandom);
				1, 2:    cnt = CNT_W'($urandom_range(1000, 200000));
				default: cnt = CNT_W'($urandom_range(0, 255));
			endcase
			send_bin(idx, cnt, closed && (k == len - 1));
			idx = idx + BIN_W'($urandom_range(1, 3));
		end
	endtask

	// defaults after reset: start at 280, window of six bins
	task automatic test_reset_defaults();
		send_bin(12'd279, 24'd900, 1'b0);
		send_bin(12'd280, 24'd10, 1'b0);
		send_bin(12'd281, 24'd50, 1'b0);
		send_bin(12'd282, 24'd20, 1'b0);
		send_bin(12'd283, 24'd5, 1'b0);
		send_bin(12'd284, 24'd70, 1'b0);
		send_bin(12'd286, 24'd40, 1'b1);
		drain();
	endtask

	// zero window length acts as one; equal counts fill slots in order
	task automatic test_field_extremes();
		write_config(12'd0, 12'd0);
		send_bin(12'd0, 24'd0, 1'b0);
		send_bin(12'd1, 24'd5, 1'b0);
		send_bin(12'd2, 24'd5, 1'b0);
		send_bin(12'd3, 24'd5, 1'b0);
		send_bin(12'd4, 24'd5, 1'b0);
		send_bin(12'd5, 24'd3, 1'b0);
		send_bin(12'hFFF, 24'hFFFFFF, 1'b1);
		drain();
	endtask

	// long windows, bins out of order, window cut at the final bin, back-to-back finals
	task automatic test_window_limits();
		write_config(12'd100, 12'hFF0);
		send_bin(12'd100, 24'd7, 1'b0);
		send_bin(12'd50, 24'd9, 1'b0);
		send_bin(12'd3000, 24'd2, 1'b0);
		send_bin(12'd10, 24'd20, 1'b1);
		drain();
		write_config(12'hFFF, 12'hFFF);
		send_bin(12'd4094, 24'h800000, 1'b1);
		send_bin(12'hFFF, 24'd1, 1'b1);
		send_bin(12'hFFF, 24'd2, 1'b1);
		send_bin(12'hFFF, 24'd0, 1'b1);
		drain();
	endtask

	task automatic test_random_histograms(input int n_bins);
		int target;
		logic [CFG_DATA_W-1:0] start_val;
		target = bins_sent + n_bins;
		while (bins_sent < target) begin
			if ($urandom_range(0, 4) == 0) begin
				drain();
				case ($urandom_range(0, 9))
					0:       start_val = '0;
					1:       start_val = '1;
					2:       start_val = CFG_DATA_W'($urandom_range(0, 4095));
					default: start_val = CFG_DATA_W'($urandom_range(0, 400));
				endcase
				write_config(start_val, CFG_DATA_W'($urandom_range(0, 4095)));
			end
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			// mostly ordered histograms, some scrambled or left unterminated
			send_histogram(($urandom_range(0, 5) == 0) ? $urandom_range(4, 40)
					: $urandom_range(1, 24),
				$urandom_range(0, 7) == 0, $urandom_range(0, 9) != 0);
		end
		drain();
	endtask

	// receiver held off while short histograms keep arriving, so the input stalls
	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = 1'b1;
		repeat (20) send_histogram($urandom_range(1, 3), 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_back_to_back(input int n_bins);
		int target;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		target = bins_sent + n_bins;
		while (bins_sent < target)
			send_histogram($urandom_range(1, 12), 1'b0, 1'b1);
		drain();
	endtask

	// result side ready, with random stall bursts and the long hold on request
	initial begin : result_sink
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 13);
				m_tready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		peak_rpt_t want;
		logic [SLOT_W-1:0] got_slot;
		logic [BIN_W-1:0]  got_bin;
		logic [CNT_W-1:0]  got_cnt;
		got_slot = m_tdata[SLOT_W-1:0];
		got_bin  = m_tdata[SLOT_W +: BIN_W];
		got_cnt  = m_tdata[SLOT_W + BIN_W +: CNT_W];
		if (arst_n && m_tvalid && m_tready) begin
			if (peak_expect_q.size() == 0) begin
				$error("unexpected result transfer: slot %0d bin %0d count %0d",
					got_slot, got_bin, got_cnt);
				fail_count++;
			end else begin
				want = peak_expect_q.pop_front();
				results_checked++;
				if (got_slot !== want.slot) begin
					$error("slot_number: expected %0d, got %0d", want.slot, got_slot);
					fail_count++;
				end
				if (got_bin !== want.bin) begin
					$error("peak_bin: expected %0d, got %0d", want.bin, got_bin);
					fail_count++;
				end
				if (got_cnt !== want.count) begin
					$error("peak_count: expected %0d, got %0d", want.count, got_cnt);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_result: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, peak_expect_q.size());
			$display("** windowed_top4_peak_finder_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		cfg_start = START_BIN_RESET;
		cfg_len   = WINDOW_LEN_RESET;
		clear_peaks();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_window_limits();
		test_random_histograms(300);
		test_output_backpressure();
		test_back_to_back(60);

		$display("%0d bins in %0d histograms sent, %0d slot results checked",
			bins_sent, hists_sent, results_checked);
		$display("covered: default and extreme registers, long output hold, random stalls");
		if (fail_count == 0 && peak_expect_q.size() == 0)
			$display("** windowed_top4_peak_finder_core: PASSED **");
		else
			$display("** windowed_top4_peak_finder_core: FAILED **");
		$finish;
	end

endmodule
